// ----- hw/rtl/awil_pkg.sv -----
package awil_pkg;

   localparam int DEPTH = 1024;
   localparam int AW = 10;
   localparam int CW = 11;

   localparam logic [3:0] MODE_GET    = 4'd0;
   localparam logic [3:0] MODE_SET    = 4'd1;
   localparam logic [3:0] MODE_INSERT = 4'd2;
   localparam logic [3:0] MODE_DELETE = 4'd3;
   localparam logic [3:0] MODE_FIND   = 4'd4;
   localparam logic [3:0] MODE_GT     = 4'd5;
   localparam logic [3:0] MODE_GE     = 4'd6;
   localparam logic [3:0] MODE_ADDLIM = 4'd7;
   localparam logic [3:0] MODE_ADDRNG = 4'd8;
   localparam logic [3:0] MODE_CLEAR  = 4'd9;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_BAD  = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef struct packed {
      logic [3:0]         mode;
      logic [10:0]        index;
      logic [10:0]        range_end;
      logic signed [63:0] value;
      logic signed [63:0] limit;
   } req_type;

   typedef struct packed {
      logic [1:0]         status;
      logic signed [63:0] read_value;
      logic [9:0]         position;
      logic               found;
      logic [10:0]        length;
      logic [2:0]         width_code;
   } rsp_type;

   // width code of one value
   function automatic logic [2:0] width_code_of(input logic [63:0] v);
      logic [63:0] m;
      m = v[63] ? ~v : v;
      if (v < 64'd16) begin
         if (v == 64'd0) return 3'd0;
         else if (v == 64'd1) return 3'd1;
         else if (v < 64'd4) return 3'd2;
         else return 3'd3;
      end else if (m[63:31] != '0) return 3'd7;
      else if (m[30:15] != '0) return 3'd6;
      else if (m[14:7] != '0) return 3'd5;
      else return 3'd4;
   endfunction

endpackage

// ----- hw/rtl/awil_alu.sv -----
module awil_alu
   import awil_pkg::*;
(
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] sum,
   output logic        eq,
   output logic        lt
);
   // shared adder and signed compare
   assign sum = a + b;
   assign eq  = (a == b);
   assign lt  = $signed(a) < $signed(b);
endmodule

// ----- hw/rtl/adaptive_width_integer_list.sv -----
// Adaptive-width integer list.
// req_ channel carries one operation item (req_type); rsp_ returns one
// result item (rsp_type) per request, in order.
// The block takes one item at a time: req_ready is high only when idle
// and no result is pending. Each item runs a sequencer around one shared
// 64-bit adder/comparator and a dual-port element memory (registered
// read). Get/set read one element; insert, delete, find and range add
// walk the elements one by one, with a read state (S_RD) and an execute
// state (S_EX) per element; the conditional add adds a write state
// (S_ADD) per element; the greater-than searches bisect (up to 11 probes).
// A synchronous reset empties the list and clears the width; no memory
// clearing is done. When rsp_ready is low the result is held in the
// output register and no new item is taken until it is delivered.
module adaptive_width_integer_list
   import awil_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_RD   = 3'd1;
   localparam logic [2:0] S_EX   = 3'd2;
   localparam logic [2:0] S_DONE = 3'd3;
   localparam logic [2:0] S_ADD  = 3'd4;

   logic [2:0]  state_ff, state_in;
   req_type     req_ff, req_in;
   logic [10:0] cnt_ff, cnt_in;
   logic [2:0]  wid_ff, wid_in;
   logic [11:0] i_ff, i_in;          // walk pointer
   logic [11:0] lo_ff, lo_in, hi_ff, hi_in;
   logic [63:0] carry_ff, carry_in;  // value carried by insert shift; add flag for the conditional add
   rsp_type     rsp_ff, rsp_in;
   logic        rv_ff, rv_in;

   logic [63:0] mem [DEPTH];
   logic [63:0] rdata_ff;
   logic [AW-1:0] raddr, waddr;
   logic [63:0] wdata;
   logic        we;

   logic [63:0] alu_a, alu_b, sum;
   logic        eq, lt;
   logic [2:0]  wc;

   awil_alu u_alu (.a(alu_a), .b(alu_b), .sum(sum), .eq(eq), .lt(lt));

   // width code of the value being written
   assign wc = width_code_of(sum);

   // element memory
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   logic [11:0] mid;
   assign mid = 12'(($signed(lo_ff) + $signed(hi_ff)) >>> 1);

   always_comb begin
      state_in = state_ff; req_in = req_ff; cnt_in = cnt_ff; wid_in = wid_ff;
      i_in = i_ff; lo_in = lo_ff; hi_in = hi_ff; carry_in = carry_ff;
      rsp_in = rsp_ff; rv_in = rv_ff;
      raddr = i_ff[AW-1:0]; waddr = i_ff[AW-1:0]; wdata = sum; we = 1'b0;
      alu_a = rdata_ff; alu_b = req_ff.value;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !rv_ff) begin
               req_in = req_data;
               rsp_in = '0;
               state_in = S_DONE;
               i_in = {1'b0, req_data.index};
               unique case (req_data.mode)
                  MODE_GET, MODE_SET: begin
                     if (req_data.index < cnt_ff) state_in = S_RD;
                     else rsp_in.status = ST_BAD;
                  end
                  MODE_INSERT: begin
                     if (req_data.index > cnt_ff) rsp_in.status = ST_BAD;
                     else if (cnt_ff >= CW'(DEPTH)) rsp_in.status = ST_FULL;
                     else begin
                        carry_in = req_data.value;
                        state_in = S_RD;
                     end
                  end
                  MODE_DELETE: begin
                     if (req_data.index < cnt_ff) begin
                        i_in = {1'b0, req_data.index} + 12'd1;
                        state_in = S_RD;
                     end else rsp_in.status = ST_BAD;
                  end
                  MODE_FIND, MODE_ADDRNG: begin
                     if (req_data.index > req_data.range_end ||
                         req_data.range_end > cnt_ff) rsp_in.status = ST_BAD;
                     else state_in = S_RD;
                  end
                  MODE_GT, MODE_GE: begin
                     lo_in = 12'hFFF; hi_in = {1'b0, cnt_ff};
                     state_in = S_RD;
                  end
                  MODE_ADDLIM: begin
                     i_in = '0;
                     state_in = S_RD;
                  end
                  MODE_CLEAR: begin
                     cnt_in = '0; wid_in = '0;
                  end
                  default: rsp_in.status = ST_BAD;
               endcase
            end
         end
         // issue a read (or finish a walk)
         S_RD: begin
            state_in = S_EX;
            unique case (req_ff.mode)
               MODE_INSERT:
                  if (i_ff > {1'b0, cnt_ff}) begin
                     cnt_in = cnt_ff + 11'd1;
                     state_in = S_DONE;
                  end
               MODE_DELETE:
                  if (i_ff >= {1'b0, cnt_ff}) begin
                     cnt_in = cnt_ff - 11'd1;
                     state_in = S_DONE;
                  end
               MODE_FIND, MODE_ADDRNG:
                  if (i_ff >= {1'b0, req_ff.range_end}) state_in = S_DONE;
               MODE_ADDLIM:
                  if (i_ff >= {1'b0, cnt_ff}) state_in = S_DONE;
               MODE_GT, MODE_GE: begin
                  raddr = mid[AW-1:0];
                  if ($signed(hi_ff) - $signed(lo_ff) <= 12'sd1) begin
                     state_in = S_DONE;
                     if (hi_ff != {1'b0, cnt_ff}) begin
                        rsp_in.found = 1'b1;
                        rsp_in.position = hi_ff[AW-1:0];
                     end
                  end
               end
               default: ;
            endcase
         end
         // act on the read data
         S_EX: begin
            state_in = S_RD;
            i_in = i_ff + 12'd1;
            unique case (req_ff.mode)
               MODE_GET: begin
                  rsp_in.read_value = rdata_ff;
                  state_in = S_DONE;
               end
               MODE_SET: begin
                  alu_a = '0;
                  we = 1'b1;
                  if (wc > wid_ff) wid_in = wc;
                  state_in = S_DONE;
               end
               MODE_INSERT: begin
                  alu_a = '0; alu_b = carry_ff;
                  we = 1'b1;
                  if (i_ff[AW-1:0] == req_ff.index[AW-1:0] && wc > wid_ff) wid_in = wc;
                  carry_in = rdata_ff;
               end
               MODE_DELETE: begin
                  alu_b = '0;
                  waddr = AW'(i_ff - 12'd1);
                  we = 1'b1;
               end
               MODE_FIND: begin
                  if (eq) begin
                     rsp_in.found = 1'b1;
                     rsp_in.position = i_ff[AW-1:0];
                     state_in = S_DONE;
                  end
               end
               MODE_ADDRNG: begin
                  we = 1'b1;
                  if (wc > wid_ff) wid_in = wc;
               end
               MODE_ADDLIM: begin
                  alu_a = rdata_ff; alu_b = req_ff.limit;
                  if (!lt) carry_in = '1; else carry_in = '0;
                  state_in = S_ADD;
               end
               MODE_GT, MODE_GE: begin
                  i_in = i_ff;
                  if (req_ff.mode == MODE_GT) begin
                     alu_a = req_ff.value; alu_b = rdata_ff;
                     if (lt) hi_in = mid; else lo_in = mid;
                  end else begin
                     if (!lt) hi_in = mid; else lo_in = mid;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         // conditional add write for mode 7
         S_ADD: begin
            state_in = S_RD;
            waddr = AW'(i_ff - 12'd1);
            if (carry_ff[0]) begin
               we = 1'b1;
               if (wc > wid_ff) wid_in = wc;
            end
         end
         S_DONE: begin
            if (!rv_ff) begin
               rsp_in.length = cnt_ff;
               rsp_in.width_code = wid_ff;
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         wid_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         wid_ff <= wid_in;
         rv_ff <= rv_in;
      end
      req_ff <= req_in;
      i_ff <= i_in;
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      carry_ff <= carry_in;
      rsp_ff <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

endmodule
